// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock, off while reset is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/bssu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssu_pkg
// word types, command codes and status codes of the breakpoint stop unit
// ----------------------------------------------------------------------------
package bssu_pkg;

   localparam int LINE_W  = 16;
   localparam int DEPTH_W = 8;
   localparam int KIND_W  = 4;
   localparam int STAT_W  = 3;
   localparam int MODE_W  = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INSTR    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_STEP     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_NEXT     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_FINISH   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_CONTINUE = 4'd4;
   localparam logic [KIND_W-1:0] KIND_ADD_BP   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DEL_BP   = 4'd6;
   localparam logic [KIND_W-1:0] KIND_DETACH   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 4'd8;

   // response status
   localparam logic [STAT_W-1:0] STAT_NONE      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_ADDED     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] STAT_REJECTED  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd4;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd5;

   // run modes
   localparam logic [MODE_W-1:0] MODE_STEP_INTO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP_OVER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINISH    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CONTINUE  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [LINE_W-1:0]  line_number;
      logic [DEPTH_W-1:0] call_depth;
   } req_type;

   typedef struct packed {
      logic               halt;
      logic [STAT_W-1:0]  status;
      logic [LINE_W-1:0]  halt_line;
   } rsp_type;

   // table update requests
   typedef struct packed {
      logic add_req;
      logic del_req;
   } bp_cmd_type;

   // table lookup results
   typedef struct packed {
      logic hit;
      logic full;
   } bp_stat_type;

endpackage

// File: rtl/breakpoint_step_stop_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_step_stop_unit
// debug stop unit: decides per instruction event whether execution halts
// ----------------------------------------------------------------------------
//  channel   ports                         direction  handshake
//  request   start, busy, req_data         in         start & !busy
//  response  rsp_valid, rsp_data           out        rsp_valid, one cycle
//
//  a request word is registered at accept, decoded against the state in the
//  next cycle, and its response word is registered from that decode; one
//  word per cycle sustained, as busy holds the flow only around reset
//  the breakpoint table is compared in parallel, which sets the decode path
//  busy is high only while reset is applied and the cycle after
//  the response side cannot stall, so each result is shown exactly once
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module breakpoint_step_stop_unit #(
   parameter int BP_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bssu_pkg::req_type req_data,
   output logic              rsp_valid,
   output bssu_pkg::rsp_type rsp_data
);

   // input register
   logic              busy_ff;
   logic              stage_valid_ff;
   bssu_pkg::req_type req_ff;

   // debugger state
   logic [bssu_pkg::MODE_W-1:0]  run_mode_ff,       run_mode_in;
   logic [bssu_pkg::DEPTH_W-1:0] captured_depth_ff, captured_depth_in;
   logic [bssu_pkg::LINE_W-1:0]  previous_line_ff,  previous_line_in;
   logic [bssu_pkg::DEPTH_W-1:0] previous_depth_ff, previous_depth_in;
   logic                         previous_valid_ff, previous_valid_in;
   logic                         detached_flag_ff,  detached_flag_in;

   // result register
   logic              rsp_valid_ff;
   bssu_pkg::rsp_type rsp_ff, rsp_in;

   bssu_pkg::bp_cmd_type  bp_cmd;
   bssu_pkg::bp_stat_type bp_stat;

   logic is_new;
   logic stop;

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         stage_valid_ff <= 1'b0;
      end else begin
         busy_ff        <= 1'b0;
         stage_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_data;
      end
   end

   bssu_bp_table #(
      .BP_ENTRIES (BP_ENTRIES)
   ) u_bp_table (
      .clock (clock),
      .reset (reset),
      .line  (req_ff.line_number),
      .cmd   (bp_cmd),
      .stat  (bp_stat)
   );

   // an event counts only when it moved off the last considered line or depth
   assign is_new = !previous_valid_ff
                   || (req_ff.line_number != previous_line_ff)
                   || (req_ff.call_depth != previous_depth_ff);

   always_comb begin
      case (run_mode_ff)
         bssu_pkg::MODE_STEP_INTO: stop = 1'b1;
         bssu_pkg::MODE_STEP_OVER: stop = (req_ff.call_depth <= captured_depth_ff)
                                          || bp_stat.hit;
         bssu_pkg::MODE_FINISH:    stop = (req_ff.call_depth < captured_depth_ff)
                                          || bp_stat.hit;
         default:                  stop = bp_stat.hit;
      endcase
   end

   // decode one request word against the current state
   always_comb begin
      run_mode_in       = run_mode_ff;
      captured_depth_in = captured_depth_ff;
      previous_line_in  = previous_line_ff;
      previous_depth_in = previous_depth_ff;
      previous_valid_in = previous_valid_ff;
      detached_flag_in  = detached_flag_ff;
      rsp_in            = '0;
      bp_cmd            = '0;
      if (stage_valid_ff) begin
         case (req_ff.kind)
            bssu_pkg::KIND_INSTR: begin
               if (!detached_flag_ff && is_new) begin
                  previous_line_in  = req_ff.line_number;
                  previous_depth_in = req_ff.call_depth;
                  previous_valid_in = 1'b1;
                  if (stop) begin
                     rsp_in.halt      = 1'b1;
                     rsp_in.halt_line = req_ff.line_number;
                  end
               end
            end
            bssu_pkg::KIND_STEP: begin
               run_mode_in = bssu_pkg::MODE_STEP_INTO;
            end
            bssu_pkg::KIND_NEXT: begin
               run_mode_in       = bssu_pkg::MODE_STEP_OVER;
               captured_depth_in = req_ff.call_depth;
            end
            bssu_pkg::KIND_FINISH: begin
               run_mode_in       = bssu_pkg::MODE_FINISH;
               captured_depth_in = req_ff.call_depth;
            end
            bssu_pkg::KIND_CONTINUE: begin
               run_mode_in = bssu_pkg::MODE_CONTINUE;
            end
            bssu_pkg::KIND_ADD_BP: begin
               // line zero is never a valid breakpoint
               if (req_ff.line_number == '0) begin
                  rsp_in.status = bssu_pkg::STAT_REJECTED;
               end else if (bp_stat.hit) begin
                  rsp_in.status = bssu_pkg::STAT_ADDED;
               end else if (bp_stat.full) begin
                  rsp_in.status = bssu_pkg::STAT_FULL;
               end else begin
                  rsp_in.status  = bssu_pkg::STAT_ADDED;
                  bp_cmd.add_req = 1'b1;
               end
            end
            bssu_pkg::KIND_DEL_BP: begin
               if (bp_stat.hit) begin
                  rsp_in.status  = bssu_pkg::STAT_DELETED;
                  bp_cmd.del_req = 1'b1;
               end else begin
                  rsp_in.status = bssu_pkg::STAT_NOT_FOUND;
               end
            end
            bssu_pkg::KIND_DETACH: begin
               detached_flag_in = 1'b1;
               run_mode_in      = bssu_pkg::MODE_CONTINUE;
            end
            bssu_pkg::KIND_ERROR: begin
               // error stops the program unless the debugger has let go
               if (!detached_flag_ff) begin
                  rsp_in.halt      = 1'b1;
                  rsp_in.halt_line = req_ff.line_number;
               end
            end
            default: begin
               // unused kinds give an all-zero word
               rsp_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff       <= bssu_pkg::MODE_STEP_INTO;
         captured_depth_ff <= '0;
         previous_line_ff  <= '0;
         previous_depth_ff <= '0;
         previous_valid_ff <= 1'b0;
         detached_flag_ff  <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         run_mode_ff       <= run_mode_in;
         captured_depth_ff <= captured_depth_in;
         previous_line_ff  <= previous_line_in;
         previous_depth_ff <= previous_depth_in;
         previous_valid_ff <= previous_valid_in;
         detached_flag_ff  <= detached_flag_in;
         rsp_valid_ff      <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `ASSERT_NEXT(a_stage_to_rsp, stage_valid_ff, rsp_valid_ff)
   `ASSERT_SAME(a_no_halt_no_line, rsp_valid_ff && !rsp_ff.halt, rsp_ff.halt_line == '0)
   `ASSERT_SAME(a_status_no_halt,
      rsp_valid_ff && (rsp_ff.status != bssu_pkg::STAT_NONE), !rsp_ff.halt)
   `ASSERT_NEXT(a_detach_sticks, detached_flag_ff,
      detached_flag_ff && (run_mode_ff == bssu_pkg::MODE_CONTINUE
                           || run_mode_ff == bssu_pkg::MODE_STEP_INTO
                           || run_mode_ff == bssu_pkg::MODE_STEP_OVER
                           || run_mode_ff == bssu_pkg::MODE_FINISH))

endmodule

// File: rtl/bssu_bp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssu_bp_table
// breakpoint line table with parallel compare and lowest-free insertion
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bssu_bp_table #(
   parameter int BP_ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bssu_pkg::LINE_W-1:0]  line,
   input  bssu_pkg::bp_cmd_type         cmd,
   output bssu_pkg::bp_stat_type        stat
);

   logic [bssu_pkg::LINE_W-1:0] bp_lines_ff [BP_ENTRIES];
   logic [BP_ENTRIES-1:0]       bp_valid_ff;
   logic [BP_ENTRIES-1:0]       bp_valid_in;
   logic [BP_ENTRIES-1:0]       match;
   logic [BP_ENTRIES-1:0]       free_vec;
   logic [BP_ENTRIES-1:0]       first_free;

   always_comb begin
      for (int i = 0; i < BP_ENTRIES; i++) begin
         match[i] = bp_valid_ff[i] && (bp_lines_ff[i] == line);
      end
   end

   assign free_vec   = ~bp_valid_ff;
   // lowest set bit of the free vector
   assign first_free = free_vec & (~free_vec + {{(BP_ENTRIES-1){1'b0}}, 1'b1});

   assign stat.hit  = |match;
   assign stat.full = &bp_valid_ff;

   always_comb begin
      bp_valid_in = bp_valid_ff;
      if (cmd.add_req) begin
         bp_valid_in = bp_valid_ff | first_free;
      end else if (cmd.del_req) begin
         bp_valid_in = bp_valid_ff & ~match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_valid_ff <= '0;
      end else begin
         bp_valid_ff <= bp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BP_ENTRIES; i++) begin
         if (cmd.add_req && first_free[i]) begin
            bp_lines_ff[i] <= line;
         end
      end
   end

   `ASSERT_NEXT(a_add_grows, cmd.add_req,
      $countones(bp_valid_ff) == $countones($past(bp_valid_ff)) + 1)
   `ASSERT_NEXT(a_del_shrinks, cmd.del_req,
      $countones(bp_valid_ff) + 1 == $countones($past(bp_valid_ff)))
   `ASSERT_SAME(a_single_match, 1'b1, $onehot0(match))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint stop unit testbench
// drives command words into the stop unit with random gaps, predicts every
// response word from an internal copy of the mode, depth and breakpoint
// table, and checks each response field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;

   import bssu_pkg::*;

   localparam int BP_ENTRIES = 16;

   // kinds the unit ignores
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

   localparam int RANDOM_WORDS   = 370;
   localparam int DETACHED_WORDS = 40;

   // no gaps in this window of the random part
   localparam int QUIET_FIRST = 150;
   localparam int QUIET_LAST  = 250;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // --------------------------------------------------------------------------
   // stop predictor and response checker
   // --------------------------------------------------------------------------
   class stop_tracker;
      bit [MODE_W-1:0]  mode = MODE_STEP_INTO;
      bit [DEPTH_W-1:0] capture_depth;
      bit [LINE_W-1:0]  last_line;
      bit [DEPTH_W-1:0] last_depth;
      bit               seen_event;
      bit               detached;
      bit [LINE_W-1:0]  bp_line [BP_ENTRIES];
      bit               bp_used [BP_ENTRIES];

      rsp_type due_rsp[$];
      int errors;
      int checked;
      int halts;
      int full_hits;
      int rejects;
      int dup_adds;

      function int find_bp(bit [LINE_W-1:0] line);
         for (int i = 0; i < BP_ENTRIES; i++)
            if (bp_used[i] && bp_line[i] == line) return i;
         return -1;
      endfunction

      function rsp_type predict_stop(req_type w);
         rsp_type r;
         int      slot;
         bit      hit;
         bit      stop;
         r = '0;
         slot = find_bp(w.line_number);
         hit = (slot >= 0);
         case (w.kind)
            KIND_INSTR: begin
               if (!detached && !(seen_event && w.line_number == last_line &&
                                  w.call_depth == last_depth)) begin
                  last_line = w.line_number;
                  last_depth = w.call_depth;
                  seen_event = 1'b1;
                  case (mode)
                     MODE_STEP_INTO: stop = 1'b1;
                     MODE_STEP_OVER: stop = (w.call_depth <= capture_depth) || hit;
                     MODE_FINISH:    stop = (w.call_depth < capture_depth) || hit;
                     default:        stop = hit;
                  endcase
                  if (stop) begin
                     r.halt = 1'b1;
                     r.halt_line = w.line_number;
                  end
               end
            end
            KIND_STEP: mode = MODE_STEP_INTO;
            KIND_NEXT: begin
               mode = MODE_STEP_OVER;
               capture_depth = w.call_depth;
            end
            KIND_FINISH: begin
               mode = MODE_FINISH;
               capture_depth = w.call_depth;
            end
            KIND_CONTINUE: mode = MODE_CONTINUE;
            KIND_ADD_BP: begin
               if (w.line_number == '0) begin
                  r.status = STAT_REJECTED;
               end else if (hit) begin
                  r.status = STAT_ADDED;
                  dup_adds++;
               end else begin
                  r.status = STAT_FULL;
                  for (int i = 0; i < BP_ENTRIES; i++) begin
                     if (!bp_used[i]) begin
                        bp_used[i] = 1'b1;
                        bp_line[i] = w.line_number;
                        r.status = STAT_ADDED;
                        break;
                     end
                  end
               end
            end
            KIND_DEL_BP: begin
               if (hit) begin
                  bp_used[slot] = 1'b0;
                  r.status = STAT_DELETED;
               end else begin
                  r.status = STAT_NOT_FOUND;
               end
            end
            KIND_DETACH: begin
               detached = 1'b1;
               mode = MODE_CONTINUE;
            end
            KIND_ERROR: begin
               if (!detached) begin
                  r.halt = 1'b1;
                  r.halt_line = w.line_number;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_word(req_type w);
         rsp_type r;
         r = predict_stop(w);
         if (r.halt) halts++;
         if (r.status == STAT_FULL) full_hits++;
         if (r.status == STAT_REJECTED) rejects++;
         due_rsp = {due_rsp, r};
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (due_rsp.size() == 0) begin
            report($sformatf("response %h with nothing outstanding", got));
            return;
         end
         want = due_rsp.pop_front();
         checked++;
         if (got.halt !== want.halt)
            report($sformatf("word %0d halt %b, want %b", checked, got.halt, want.halt));
         if (got.status !== want.status)
            report($sformatf("word %0d status %0d, want %0d", checked, got.status,
                             want.status));
         if (got.halt_line !== want.halt_line)
            report($sformatf("word %0d halt_line %h, want %h", checked, got.halt_line,
                             want.halt_line));
      endtask

      function int pending();
         return due_rsp.size();
      endfunction
   endclass

   stop_tracker tracker;

   // last instruction event handed out, so repeats can be generated
   logic [LINE_W-1:0]  gen_line;
   logic [DEPTH_W-1:0] gen_depth;

   breakpoint_step_stop_unit #(
      .BP_ENTRIES(BP_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the unit hangs or drops responses
   initial begin
      #200000;
      $display("timeout: %0d responses still outstanding", tracker.pending());
      $display("== FAIL ==");
      $finish;
   end

   // response side cannot stall, so just watch every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            tracker.check_word(rsp_data);
         else if (rsp_valid !== 1'b0)
            tracker.report("rsp_valid is unknown");
      end
   end

   function automatic req_type make_word(logic [KIND_W-1:0] kind, logic [LINE_W-1:0] line,
                                         logic [DEPTH_W-1:0] depth);
      req_type w;
      w.kind = kind;
      w.line_number = line;
      w.call_depth = depth;
      return w;
   endfunction

   // present one word and hold it until the unit takes it
   task automatic send_word(req_type w);
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      tracker.note_word(w);
   endtask

   // drop start and idle, with junk on the data lines
   task automatic idle_cycles(int n);
      start <= 1'b0;
      req_data <= req_type'($urandom);
      repeat (n) @(posedge clock);
   endtask

   // mostly a small pool of lines so breakpoints get hit and the table fills
   function automatic logic [LINE_W-1:0] pick_line();
      if ($urandom_range(99) < 70) return LINE_W'($urandom_range(24, 1) * 16'h0a03);
      return LINE_W'($urandom_range(16'hffff));
   endfunction

   // shallow depths most of the time so the depth compares flip often
   function automatic logic [DEPTH_W-1:0] pick_depth();
      if ($urandom_range(99) < 75) return DEPTH_W'($urandom_range(6));
      return DEPTH_W'($urandom_range(255));
   endfunction

   function automatic req_type random_word();
      int roll;
      req_type w;
      roll = $urandom_range(99);
      w = make_word(KIND_INSTR, pick_line(), pick_depth());
      if (roll < 43) begin
         gen_line = w.line_number;
         gen_depth = w.call_depth;
      end else if (roll < 49) begin
         // same event again, must be ignored
         w.line_number = gen_line;
         w.call_depth = gen_depth;
      end else if (roll < 54) begin
         w.kind = KIND_STEP;
      end else if (roll < 59) begin
         w.kind = KIND_NEXT;
      end else if (roll < 64) begin
         w.kind = KIND_FINISH;
      end else if (roll < 69) begin
         w.kind = KIND_CONTINUE;
      end else if (roll < 83) begin
         w.kind = KIND_ADD_BP;
         if ($urandom_range(19) == 0) w.line_number = '0;
      end else if (roll < 91) begin
         w.kind = KIND_DEL_BP;
         if ($urandom_range(19) == 0) w.line_number = '0;
      end else if (roll < 96) begin
         w.kind = KIND_ERROR;
      end else begin
         w.kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end
      return w;
   endfunction

   // about three words in ten are followed by a gap
   task automatic maybe_gap(int idx);
      if (idx >= QUIET_FIRST && idx < QUIET_LAST) return;
      if ($urandom_range(99) < 30) idle_cycles($urandom_range(2, 1));
   endtask

   initial begin
      req_type directed[$];
      tracker = new;
      gen_line = '0;
      gen_depth = '0;
      start <= 1'b0;
      req_data <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // error first, then the very first event at line zero is still new
      directed = {directed, make_word(KIND_ERROR, 16'hffff, 8'h00)};
      directed = {directed, make_word(KIND_INSTR, 16'h0000, 8'h00)};
      directed = {directed, make_word(KIND_INSTR, 16'h0000, 8'h00)};
      directed = {directed, make_word(KIND_INSTR, 16'hffff, 8'hff)};
      // breakpoint edge cases: line zero, top line, duplicate, missing delete
      directed = {directed, make_word(KIND_ADD_BP, 16'h0000, 8'h00)};
      directed = {directed, make_word(KIND_ADD_BP, 16'hffff, 8'h00)};
      directed = {directed, make_word(KIND_ADD_BP, 16'hffff, 8'hff)};
      directed = {directed, make_word(KIND_DEL_BP, 16'h0000, 8'h00)};
      // step over around a captured depth
      directed = {directed, make_word(KIND_NEXT, 16'h1234, 8'h80)};
      directed = {directed, make_word(KIND_INSTR, 16'h0064, 8'h81)};
      directed = {directed, make_word(KIND_INSTR, 16'hffff, 8'h81)};
      directed = {directed, make_word(KIND_INSTR, 16'h0005, 8'h80)};
      // finish stops strictly below the captured depth, or on a breakpoint
      directed = {directed, make_word(KIND_FINISH, 16'h0000, 8'h80)};
      directed = {directed, make_word(KIND_INSTR, 16'h0006, 8'h80)};
      directed = {directed, make_word(KIND_INSTR, 16'h0007, 8'h7f)};
      // continue only stops on a breakpoint
      directed = {directed, make_word(KIND_CONTINUE, 16'h0000, 8'h00)};
      directed = {directed, make_word(KIND_INSTR, 16'h0008, 8'h00)};
      directed = {directed, make_word(KIND_INSTR, 16'hffff, 8'h00)};
      directed = {directed, make_word(KIND_DEL_BP, 16'hffff, 8'h00)};
      directed = {directed, make_word(KIND_DEL_BP, 16'hffff, 8'h00)};
      directed = {directed, make_word(KIND_INSTR, 16'h0009, 8'h00)};
      directed = {directed, make_word(KIND_UNUSED_HI, 16'hffff, 8'hff)};
      directed = {directed, make_word(KIND_UNUSED_LO, 16'h5a5a, 8'ha5)};
      directed = {directed, make_word(KIND_STEP, 16'hffff, 8'hff)};
      directed = {directed, make_word(KIND_INSTR, 16'h0009, 8'h01)};

      foreach (directed[i]) begin
         send_word(directed[i]);
         if ($urandom_range(99) < 30) idle_cycles($urandom_range(2, 1));
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         send_word(random_word());
         maybe_gap(i);
      end

      // detach is sticky until reset, so it closes the run
      send_word(make_word(KIND_DETACH, pick_line(), pick_depth()));
      for (int i = 0; i < DETACHED_WORDS; i++) begin
         send_word(random_word());
         maybe_gap(0);
      end

      // let the last responses drain, then keep watching for stray words
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("checked %0d responses: %0d halts, %0d table-full, %0d rejected lines,",
               tracker.checked, tracker.halts, tracker.full_hits, tracker.rejects);
      $display("%0d duplicate adds, last %0d words sent after detach",
               tracker.dup_adds, DETACHED_WORDS);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", tracker.errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
